### sv/hbrl_pkg.sv
// Shared constants for the hashed bucket rate limiter.
package hbrl_pkg;

	localparam int CFG_W = 11;
	localparam int KEY_W = 32;
	localparam int STAMP_W = 5;
	localparam int COUNT_W = 3;
	localparam int ENTRY_W = STAMP_W + COUNT_W;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 3'd7;
	localparam logic [KEY_W-1:0] MULT_CONST = 32'd2654435761;
	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_BITS = 4;

endpackage

### sv/hashed_bucket_rate_limiter.sv
// Top level of the hashed bucket rate limiter.
//
//   channel   signals                                           handshake
//   request   is_ipv6, key_word0, key_word1, elapsed_seconds    push / full
//   result    allowed                                           pop / empty
//   config    bucket_count_wdata                                bucket_count_we
//
// The front end holds one request through capture, the address mix (ST_MIX_A, ST_MIX_B),
// the multiply, the iterative modulo (DIV_BITS dividend bits per step) and the queue write.
// With limiting disabled a request skips the hash and goes from capture to the queue write.
// The back end reads the table when it pops a limited request and writes back in ST_UPDATE.
// After reset the table is swept to zero, and full is high throughout the sweep.
// A result left on the result port stalls the back end, and the front once the queue is full.
module hashed_bucket_rate_limiter #(
	parameter int TABLE_DEPTH = hbrl_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       is_ipv6,
	input  logic [hbrl_pkg::KEY_W-1:0] key_word0,
	input  logic [hbrl_pkg::KEY_W-1:0] key_word1,
	input  logic [hbrl_pkg::KEY_W-1:0] elapsed_seconds,
	output logic                       empty,
	input  logic                       pop,
	output logic                       allowed,
	input  logic                       bucket_count_we,
	input  logic [hbrl_pkg::CFG_W-1:0] bucket_count_wdata
);
	import hbrl_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int QW = IDX_W + STAMP_W + 1;

	logic [CFG_W-1:0] bucket_count_q;
	logic             clearing;
	logic             fq_push, fq_full, fq_pop, fq_empty;
	logic [QW-1:0]    fq_wdata, fq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= '0;
		end else if (bucket_count_we) begin
			bucket_count_q <= bucket_count_wdata;
		end
	end

	hbrl_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.is_ipv6(is_ipv6),
		.key_word0(key_word0),
		.key_word1(key_word1),
		.elapsed_seconds(elapsed_seconds),
		.bucket_count(bucket_count_q),
		.hold(clearing),
		.q_push(fq_push),
		.q_full(fq_full),
		.q_data(fq_wdata)
	);

	hbrl_fifo #(
		.W(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(fq_push),
		.wr_data(fq_wdata),
		.is_full(fq_full),
		.rd_en(fq_pop),
		.rd_data(fq_rdata),
		.is_empty(fq_empty)
	);

	hbrl_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(fq_empty),
		.q_data(fq_rdata),
		.q_pop(fq_pop),
		.clearing(clearing),
		.empty(empty),
		.pop(pop),
		.allowed(allowed)
	);

	a_hold_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("request port open while the table is being cleared");

endmodule

### sv/hbrl_front.sv
// Front end: accepts requests, hashes the address and reduces it modulo the bucket count.
module hbrl_front #(
	parameter int TABLE_DEPTH = hbrl_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        is_ipv6,
	input  logic [hbrl_pkg::KEY_W-1:0]  key_word0,
	input  logic [hbrl_pkg::KEY_W-1:0]  key_word1,
	input  logic [hbrl_pkg::KEY_W-1:0]  elapsed_seconds,
	input  logic [hbrl_pkg::CFG_W-1:0]  bucket_count,
	input  logic                        hold,
	output logic                        q_push,
	input  logic                        q_full,
	output logic [IDX_W+hbrl_pkg::STAMP_W:0] q_data
);
	import hbrl_pkg::*;

	localparam logic [CFG_W-1:0] DEPTH_CAP =
		(TABLE_DEPTH > (2 ** CFG_W) - 1) ? '1 : CFG_W'(TABLE_DEPTH);
	localparam int DIV_STEPS = KEY_W / DIV_BITS;
	localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_A,
		ST_MIX_B,
		ST_MUL,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t              state_q;
	logic [KEY_W-1:0]    k0_q, k1_q;
	logic                v6_q;
	logic                bypass_q;
	logic [STAMP_W-1:0]  window_q;
	logic [CFG_W-1:0]    n_q;
	logic [CFG_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CFG_W-1:0]    n_sat;
	logic [CFG_W-1:0]    rem_next;
	logic [KEY_W-1:0]    dvd_next;
	logic [KEY_W-1:0]    hash;
	logic [IDX_W+CFG_W-1:0] rem_ext;

	function automatic logic [KEY_W-1:0] mix_a(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		t = k + (k << 12);
		t = t ^ (t >> 22);
		t = t + (t << 4);
		t = t ^ (t >> 9);
		return t;
	endfunction

	function automatic logic [KEY_W-1:0] mix_b(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		t = k + (k << 10);
		t = t ^ (t >> 2);
		t = t + (t << 7);
		t = t ^ (t >> 12);
		return t;
	endfunction

	assign n_sat = (bucket_count > DEPTH_CAP) ? DEPTH_CAP : bucket_count;

	// The IPv6 lane only contributes when the family says so.
	always_comb begin
		logic [KEY_W-1:0] h0, h1;
		h0 = (k0_q >> 3) * MULT_CONST;
		h1 = (k1_q >> 3) * MULT_CONST;
		hash = v6_q ? (h0 ^ h1) : h0;
	end

	// Restoring remainder, several dividend bits per cycle; k0_q serves as the dividend.
	always_comb begin
		logic [CFG_W:0] t;
		logic [CFG_W-1:0] r;
		logic [KEY_W-1:0] d;
		r = rem_q;
		d = k0_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, d[KEY_W-1]};
			d = d << 1;
			if (t >= {1'b0, n_q}) begin
				t = t - {1'b0, n_q};
			end
			r = t[CFG_W-1:0];
		end
		rem_next = r;
		dvd_next = d;
	end

	assign rem_ext = {{IDX_W{1'b0}}, rem_q};
	assign q_data = {bypass_q, window_q, rem_ext[IDX_W-1:0]};
	assign q_push = (state_q == ST_PUSH) && !q_full;
	assign full = (state_q != ST_IDLE) || hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k0_q <= '0;
			k1_q <= '0;
			v6_q <= 1'b0;
			bypass_q <= 1'b0;
			window_q <= '0;
			n_q <= '0;
			rem_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push && !full) begin
						k0_q <= key_word0;
						k1_q <= key_word1;
						v6_q <= is_ipv6;
						window_q <= elapsed_seconds[STAMP_W-1:0];
						n_q <= n_sat;
						bypass_q <= (n_sat == '0);
						rem_q <= '0;
						step_q <= '0;
						state_q <= (n_sat == '0) ? ST_PUSH : ST_MIX_A;
					end
				end
				ST_MIX_A: begin
					k0_q <= mix_a(k0_q);
					k1_q <= mix_a(k1_q);
					state_q <= ST_MIX_B;
				end
				ST_MIX_B: begin
					k0_q <= mix_b(k0_q);
					k1_q <= mix_b(k1_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					k0_q <= hash;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					k0_q <= dvd_next;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && !bypass_q) |-> (rem_q < n_q && n_q != '0))
		else $error("bucket index not below bucket count");

endmodule

### sv/hbrl_fifo.sv
// Short queue between the hashing front end and the bucket update back end.
module hbrl_fifo #(
	parameter int W = 8,
	parameter int DEPTH = hbrl_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         is_full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         is_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_wr = wr_en && !is_full;
	assign do_rd = rd_en && !is_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond its depth");

endmodule

### sv/hbrl_back.sv
// Back end: clears the bucket table after reset and performs the bucket read-modify-write.
module hbrl_back #(
	parameter int TABLE_DEPTH = hbrl_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  logic [IDX_W+hbrl_pkg::STAMP_W:0] q_data,
	output logic                             q_pop,
	output logic                             clearing,
	output logic                             empty,
	input  logic                             pop,
	output logic                             allowed
);
	import hbrl_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t             state_q;
	logic [ENTRY_W-1:0] table_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [STAMP_W-1:0] window_q;
	logic               res_valid_q;
	logic               res_allowed_q;
	logic               out_free;
	logic               res_load;
	logic               head_bypass;
	logic [IDX_W-1:0]   head_idx;
	logic [STAMP_W-1:0] head_window;
	logic               rd_en;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] upd_entry;
	logic               upd_write;
	logic               upd_allow;
	logic [STAMP_W-1:0] stamp;
	logic [COUNT_W-1:0] count;

	assign {head_bypass, head_window, head_idx} = q_data;
	assign out_free = !res_valid_q || pop;
	assign q_pop = (state_q == ST_IDLE) && !q_empty && (!head_bypass || out_free);
	assign rd_en = q_pop && !head_bypass;
	assign clearing = (state_q == ST_CLEAR);
	assign empty = !res_valid_q;
	assign allowed = res_allowed_q;
	// A result is loaded either straight from a bypass request or at the end of an update.
	assign res_load = (q_pop && head_bypass) || (state_q == ST_UPDATE && out_free);

	assign stamp = rdata_q[ENTRY_W-1:COUNT_W];
	assign count = rdata_q[COUNT_W-1:0];

	// A new second restarts the bucket; a full bucket in the same second denies.
	always_comb begin
		upd_entry = {window_q, count + 1'b1};
		upd_write = 1'b1;
		upd_allow = 1'b1;
		if (stamp != window_q) begin
			upd_entry = {window_q, {COUNT_W{1'b0}}};
		end else if (count == COUNT_LIMIT) begin
			upd_write = 1'b0;
			upd_allow = 1'b0;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = upd_entry;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_UPDATE && out_free) begin
			we = upd_write;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= table_q[head_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			window_q <= '0;
			res_valid_q <= 1'b0;
			res_allowed_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						if (head_bypass) begin
							res_allowed_q <= 1'b1;
						end else begin
							idx_q <= head_idx;
							window_q <= head_window;
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						res_allowed_q <= upd_allow;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !res_valid_q)
		else $error("result present while the table is being cleared");

	a_update_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_UPDATE || $past(q_pop)))
		else $error("bucket update entered without a request from the queue");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the hashed bucket rate limiter.
`timescale 1ns / 100ps

module tb_top;
	import hbrl_pkg::*;

	localparam int TABLE_SIZE = DEFAULT_TABLE_DEPTH;
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int SETTLE_CYCLES = 32;
	// Longest quiet stretch of a correct run is the table sweep after reset
	// or the receiver hold-off; allow several times that.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DIRECTED_COUNT = 20;

	typedef enum logic [1:0] {
		VERDICT_PREDICTED,
		VERDICT_ALLOW,
		VERDICT_DENY
	} verdict_e;

	typedef enum logic [1:0] {
		POP_STEADY,
		POP_HALF,
		POP_SPARSE
	} pop_mode_e;

	typedef struct packed {
		logic [CFG_W-1:0] limit;
		logic             v6;
		logic [KEY_W-1:0] w0;
		logic [KEY_W-1:0] w1;
		logic [KEY_W-1:0] secs;
		verdict_e         verdict;
	} directed_row_t;

	// With one bucket every request lands in bucket 0, so the count is easy to follow.
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{11'd0,    1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, VERDICT_ALLOW},
		'{11'd0,    1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, VERDICT_ALLOW},
		'{11'd1,    1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, VERDICT_ALLOW},
		'{11'd1,    1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0020, VERDICT_ALLOW},
		'{11'd1,    1'b0, 32'h8000_0000, 32'h0000_0001, 32'h0000_0040, VERDICT_ALLOW},
		'{11'd1,    1'b1, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, VERDICT_ALLOW},
		'{11'd1,    1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFE0, VERDICT_ALLOW},
		'{11'd1,    1'b1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h7FFF_FFE0, VERDICT_ALLOW},
		'{11'd1,    1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_1000, VERDICT_ALLOW},
		'{11'd1,    1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, VERDICT_DENY},
		'{11'd1,    1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, VERDICT_ALLOW},
		'{11'd1,    1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFE1, VERDICT_ALLOW},
		'{11'd1024, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, VERDICT_PREDICTED},
		'{11'd1024, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_001F, VERDICT_PREDICTED},
		'{11'd2047, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_001F, VERDICT_PREDICTED},
		'{11'd2047, 1'b0, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_001F, VERDICT_PREDICTED},
		'{11'd2047, 1'b0, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_001F, VERDICT_PREDICTED},
		'{11'd3,    1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001, VERDICT_PREDICTED},
		'{11'd1,    1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, VERDICT_PREDICTED},
		'{11'd0,    1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, VERDICT_ALLOW}
	};

	logic             clk;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic             is_ipv6 = 1'b0;
	logic [KEY_W-1:0] key_word0 = '0;
	logic [KEY_W-1:0] key_word1 = '0;
	logic [KEY_W-1:0] elapsed_seconds = '0;
	logic             empty;
	logic             pop = 1'b0;
	logic             allowed;
	logic             bucket_count_we = 1'b0;
	logic [CFG_W-1:0] bucket_count_wdata = '0;

	logic [ENTRY_W-1:0] rate_table [TABLE_SIZE];
	logic [CFG_W-1:0]   limit_buckets = '0;
	logic               expected_verdicts [$];

	logic        hold_off_request = 1'b0;
	logic        flush_results = 1'b0;
	int unsigned mismatches = 0;
	int unsigned requests_accepted = 0;
	int unsigned allowed_seen = 0;
	int unsigned denied_seen = 0;
	int unsigned settings_written = 0;

	hashed_bucket_rate_limiter u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.is_ipv6            (is_ipv6),
		.key_word0          (key_word0),
		.key_word1          (key_word1),
		.elapsed_seconds    (elapsed_seconds),
		.empty              (empty),
		.pop                (pop),
		.allowed            (allowed),
		.bucket_count_we    (bucket_count_we),
		.bucket_count_wdata (bucket_count_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] scramble_key(input logic [KEY_W-1:0] k);
		k = k + (k << 12);
		k ^= k >> 22;
		k = k + (k << 4);
		k ^= k >> 9;
		k = k + (k << 10);
		k ^= k >> 2;
		k = k + (k << 7);
		k ^= k >> 12;
		return (k >> 3) * MULT_CONST;
	endfunction

	// Updates the bucket table copy and returns whether the request gets through.
	function automatic logic admit_request(input logic v6, input logic [KEY_W-1:0] w0,
			input logic [KEY_W-1:0] w1, input logic [KEY_W-1:0] secs);
		logic [KEY_W-1:0]   h;
		logic [KEY_W-1:0]   span;
		int                 slot;
		logic [STAMP_W-1:0] window;
		logic [ENTRY_W-1:0] entry;
		if (limit_buckets == '0)
			return 1'b1;
		span = (32'(limit_buckets) > 32'(TABLE_SIZE)) ? 32'(TABLE_SIZE) : 32'(limit_buckets);
		h = scramble_key(w0);
		if (v6)
			h ^= scramble_key(w1);
		slot = int'(h % span);
		entry = rate_table[slot];
		window = secs[STAMP_W-1:0];
		if (entry[ENTRY_W-1:COUNT_W] != window) begin
			rate_table[slot] = {window, {COUNT_W{1'b0}}};
			return 1'b1;
		end
		if (entry[COUNT_W-1:0] == COUNT_LIMIT)
			return 1'b0;
		rate_table[slot] = {window, entry[COUNT_W-1:0] + 1'b1};
		return 1'b1;
	endfunction

	// Leaves push high on return; the caller lowers it when a gap follows.
	task automatic offer_request(input logic v6, input logic [KEY_W-1:0] w0,
			input logic [KEY_W-1:0] w1, input logic [KEY_W-1:0] secs, input verdict_e verdict);
		logic predicted;
		push <= 1'b1;
		is_ipv6 <= v6;
		key_word0 <= w0;
		key_word1 <= w1;
		elapsed_seconds <= secs;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = admit_request(v6, w0, w1, secs);
		case (verdict)
			VERDICT_ALLOW: expected_verdicts.push_back(1'b1);
			VERDICT_DENY: expected_verdicts.push_back(1'b0);
			default: expected_verdicts.push_back(predicted);
		endcase
		requests_accepted++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_bucket_count(input logic [CFG_W-1:0] value);
		bucket_count_we <= 1'b1;
		bucket_count_wdata <= value;
		@(posedge clk);
		bucket_count_we <= 1'b0;
		limit_buckets = value;
		settings_written++;
	endtask

	// Result side: checks every popped result and runs its own stall pattern.
	initial begin
		pop_mode_e   mode;
		int unsigned mode_left;
		int unsigned hold_left;
		logic        want;
		mode = POP_STEADY;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0) begin
					$error("allowed: no request outstanding, expected none, actual %0b", allowed);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (allowed !== want) begin
						$error("allowed: expected %0b, actual %0b", want, allowed);
						mismatches++;
					end else if (want) begin
						allowed_seen++;
					end else begin
						denied_seen++;
					end
				end
			end
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (flush_results) begin
				pop <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = pop_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					POP_STEADY: pop <= 1'b1;
					POP_HALF: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || bucket_count_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned      phase_limits [PHASE_COUNT];
		logic             pool_v6 [8];
		logic [KEY_W-1:0] pool_w0 [8];
		logic [KEY_W-1:0] pool_w1 [8];
		int unsigned      pool_size;
		int unsigned      pick;
		int unsigned      member;
		int unsigned      burst_left;
		int unsigned      gap;
		logic [KEY_W-1:0] current_second;
		logic             v6;
		logic [KEY_W-1:0] w0;
		logic [KEY_W-1:0] w1;
		logic [KEY_W-1:0] secs;

		foreach (rate_table[i])
			rate_table[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].limit != limit_buckets) begin
				drain_results();
				set_bucket_count(DIRECTED_ROWS[r].limit);
			end
			offer_request(DIRECTED_ROWS[r].v6, DIRECTED_ROWS[r].w0, DIRECTED_ROWS[r].w1,
				DIRECTED_ROWS[r].secs, DIRECTED_ROWS[r].verdict);
		end

		phase_limits = '{3, 1024, 0, 2047, 1, 0, 64, 0, 5, 0};
		phase_limits[5] = $urandom_range(2, 1023);
		phase_limits[7] = $urandom_range(2, 1023);
		phase_limits[9] = $urandom_range(1025, 2047);
		burst_left = 0;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			set_bucket_count(CFG_W'(phase_limits[p]));
			// A small set of busy clients in a slowly moving second drives buckets to the limit.
			pool_size = $urandom_range(1, 8);
			for (int c = 0; c < 8; c++) begin
				pool_v6[c] = 1'($urandom_range(0, 1));
				pool_w0[c] = $urandom;
				pool_w1[c] = $urandom;
			end
			current_second = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 30)
					hold_off_request = 1'b1;
				pick = $urandom_range(0, 99);
				secs = $urandom;
				secs[STAMP_W-1:0] = current_second[STAMP_W-1:0];
				if (pick < 75) begin
					member = $urandom_range(0, pool_size - 1);
					v6 = pool_v6[member];
					w0 = pool_w0[member];
					w1 = pool_w1[member];
				end else begin
					v6 = 1'($urandom_range(0, 1));
					w0 = $urandom;
					w1 = $urandom;
					if (pick >= 90)
						secs = $urandom;
				end
				if ($urandom_range(0, 149) == 0)
					current_second++;
				offer_request(v6, w0, w1, secs, VERDICT_PREDICTED);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap = $urandom_range(0, 8);
					if (gap != 0) begin
						push <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end else begin
					burst_left--;
				end
			end
		end

		flush_results = 1'b1;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d requests under %0d bucket-count settings: %0d allowed, %0d denied",
			requests_accepted, settings_written, allowed_seen, denied_seen);
		$display("tb: limiting off, one bucket, full and oversized tables, and a long result stall");
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
